[rtl/core/slt_pkg.sv]
// Package for the source lexer tokenizer: item types, scanner state, token kinds,
// character codes, character class helpers and saturating increment helpers. No dependencies.
package slt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 16;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int KIND_BITS   = 6;

  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LENGTH_BITS-1:0] length_t;
  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COLUMN_BITS-1:0] column_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_t   token_kind;
    offset_t start_offset;
    length_t token_length;
    line_t   line_number;
    column_t column_number;
    logic    run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } slt_push_t;

  typedef enum logic [4:0] {
    M_IDLE, M_MINUS, M_PLUS, M_STAR, M_SLASH, M_LESS, M_GREATER, M_AMP,
    M_PIPE, M_EQ, M_EQEQ, M_COLON, M_HEADER, M_WORD, M_NUMBER, M_NUMFIRST,
    M_HEX, M_LCOMMENT, M_BLOCK, M_BLOCKSTAR, M_SQ, M_DQ, M_SQESC, M_DQESC
  } mode_t;

  typedef struct packed {
    mode_t   mode;
    kind_t   kind;
    offset_t start;
    length_t len;
    line_t   line;
    column_t col;
    offset_t off;
    line_t   cur_line;
    column_t cur_col;
    logic    dot;
  } scan_state_t;

  localparam scan_state_t ST_RESET = '{
    mode: M_IDLE, kind: '0, start: '0, len: '0, line: LINE_BITS'(1),
    col: COLUMN_BITS'(1), off: '0, cur_line: LINE_BITS'(1),
    cur_col: COLUMN_BITS'(1), dot: 1'b0
  };

  localparam kind_t TK_UNDEF     = 6'd0;
  localparam kind_t TK_LBRACE    = 6'd1;
  localparam kind_t TK_RBRACE    = 6'd2;
  localparam kind_t TK_LPAREN    = 6'd3;
  localparam kind_t TK_RPAREN    = 6'd4;
  localparam kind_t TK_LBRACK    = 6'd5;
  localparam kind_t TK_RBRACK    = 6'd6;
  localparam kind_t TK_LITERAL   = 6'd7;
  localparam kind_t TK_ARROW     = 6'd9;
  localparam kind_t TK_DEC       = 6'd10;
  localparam kind_t TK_SUB_ASGN  = 6'd11;
  localparam kind_t TK_MINUS     = 6'd12;
  localparam kind_t TK_SEMI      = 6'd13;
  localparam kind_t TK_PLUS      = 6'd14;
  localparam kind_t TK_INC       = 6'd15;
  localparam kind_t TK_ADD_ASGN  = 6'd16;
  localparam kind_t TK_HEADER    = 6'd17;
  localparam kind_t TK_LT        = 6'd18;
  localparam kind_t TK_LE        = 6'd19;
  localparam kind_t TK_GT        = 6'd20;
  localparam kind_t TK_GE        = 6'd21;
  localparam kind_t TK_EQEQ      = 6'd22;
  localparam kind_t TK_BSLASH    = 6'd23;
  localparam kind_t TK_COMMA     = 6'd24;
  localparam kind_t TK_DOT       = 6'd25;
  localparam kind_t TK_COLON     = 6'd26;
  localparam kind_t TK_ASSIGN    = 6'd27;
  localparam kind_t TK_EQEQ_GT   = 6'd28;
  localparam kind_t TK_DARROW    = 6'd29;
  localparam kind_t TK_SCOPE     = 6'd30;
  localparam kind_t TK_SQ_STR    = 6'd31;
  localparam kind_t TK_DQ_STR    = 6'd32;
  localparam kind_t TK_STAR      = 6'd33;
  localparam kind_t TK_MUL_ASGN  = 6'd34;
  localparam kind_t TK_SLASH     = 6'd35;
  localparam kind_t TK_DIV_ASGN  = 6'd36;
  localparam kind_t TK_BLOCK_CMT = 6'd37;
  localparam kind_t TK_LINE_CMT  = 6'd38;
  localparam kind_t TK_LAND      = 6'd39;
  localparam kind_t TK_LOR       = 6'd40;
  localparam kind_t TK_AMP       = 6'd41;
  localparam kind_t TK_PIPE      = 6'd42;
  localparam kind_t TK_INT       = 6'd43;
  localparam kind_t TK_HEX       = 6'd44;
  localparam kind_t TK_FLOAT     = 6'd45;
  localparam kind_t TK_BANG      = 6'd46;
  localparam kind_t TK_QUEST     = 6'd47;
  localparam kind_t TK_LAST      = TK_QUEST;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_letter(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic length_t inc_len(input length_t v);
    return (v == '1) ? v : v + LENGTH_BITS'(1);
  endfunction

  function automatic line_t inc_line(input line_t v);
    return (v == '1) ? v : v + LINE_BITS'(1);
  endfunction

  function automatic column_t inc_col(input column_t v);
    return (v == '1) ? v : v + COLUMN_BITS'(1);
  endfunction

endpackage

[rtl/core/source_lexer_tokenizer.sv]
// Top level of the source lexer tokenizer: scanner plus result queue.
// Depends on slt_pkg, slt_scanner and slt_outq.
//
// Source bytes go in one per item and tokens come out one per item, each with its kind,
// start offset, length, line and column; run_last marks the last token a byte caused.
// A byte is taken whenever the four-entry result queue has room for two tokens, so a
// steady stream runs at one byte per clock while the sink keeps up; a byte that closes
// one token and emits another leaves two tokens to drain. Tokens of an accepted byte
// are registered in the result queue. A byte with end_of_text flushes any open token
// and the following byte starts a fresh text at offset 0, line 1, column 1.
module source_lexer_tokenizer import slt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  slt_push_t push;
  logic      accept;

  assign accept = in_valid && in_ready;

  slt_scanner u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  slt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/slt_scanner.sv]
// Scanner: the tokenizer state registers and the per-byte next-state logic.
// Produces up to two token items per accepted byte. Depends on slt_pkg.
module slt_scanner import slt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  in_data,
  output slt_push_t push
);

  scan_state_t st_r, st_nxt;
  scan_state_t st_mid;
  logic [7:0]  b;
  logic        taken, cr_skip;
  logic        do_cmp, do_grow, do_flush, do_close;
  kind_t       cmp_kind;
  logic        ext_emit, st_emit, eot_emit;
  kind_t       ext_kind, st_kind;
  length_t     ext_len;
  logic        beg, beg_str;
  mode_t       beg_mode;
  kind_t       beg_kind;
  out_item_t   ext_item, st_item, eot_item;

  assign b = in_data.source_byte;

  always_comb begin
    st_mid   = st_r;
    do_cmp   = 1'b0;
    do_grow  = 1'b0;
    do_flush = 1'b0;
    do_close = 1'b0;
    cmp_kind = TK_UNDEF;
    case (st_r.mode)
      M_IDLE: begin
      end
      M_MINUS: begin
        if (b == CH_GT) begin
          do_cmp = 1'b1; cmp_kind = TK_ARROW;
        end else if (b == CH_MINUS) begin
          do_cmp = 1'b1; cmp_kind = TK_DEC;
        end else if (b == CH_EQ) begin
          do_cmp = 1'b1; cmp_kind = TK_SUB_ASGN;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_PLUS: begin
        if (b == CH_PLUS) begin
          do_cmp = 1'b1; cmp_kind = TK_INC;
        end else if (b == CH_EQ) begin
          do_cmp = 1'b1; cmp_kind = TK_ADD_ASGN;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_STAR: begin
        if (b == CH_EQ) begin
          do_cmp = 1'b1; cmp_kind = TK_MUL_ASGN;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_SLASH: begin
        if (b == CH_EQ) begin
          do_cmp = 1'b1; cmp_kind = TK_DIV_ASGN;
        end else if (b == CH_SLASH) begin
          do_grow = 1'b1; st_mid.mode = M_LCOMMENT; st_mid.kind = TK_LINE_CMT;
        end else if (b == CH_STAR) begin
          do_grow = 1'b1; st_mid.mode = M_BLOCK; st_mid.kind = TK_BLOCK_CMT;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_LESS: begin
        if (b == CH_QUEST) begin
          do_grow = 1'b1; st_mid.mode = M_HEADER; st_mid.kind = TK_HEADER;
        end else if (b == CH_EQ) begin
          do_cmp = 1'b1; cmp_kind = TK_LE;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_GREATER: begin
        if (b == CH_EQ) begin
          do_cmp = 1'b1; cmp_kind = TK_GE;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_AMP: begin
        if (b == CH_AMP) begin
          do_cmp = 1'b1; cmp_kind = TK_LAND;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_PIPE: begin
        if (b == CH_PIPE) begin
          do_cmp = 1'b1; cmp_kind = TK_LOR;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_EQ: begin
        if (b == CH_EQ) begin
          do_grow = 1'b1; st_mid.mode = M_EQEQ; st_mid.kind = TK_EQEQ;
        end else if (b == CH_GT) begin
          do_cmp = 1'b1; cmp_kind = TK_DARROW;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_EQEQ: begin
        if (b == CH_GT) begin
          do_cmp = 1'b1; cmp_kind = TK_EQEQ_GT;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_COLON: begin
        if (b == CH_COLON) begin
          do_cmp = 1'b1; cmp_kind = TK_SCOPE;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_HEADER: begin
        if (is_letter(b)) begin
          do_grow = 1'b1;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_WORD: begin
        if (is_letter(b) || is_digit(b)) begin
          do_grow = 1'b1;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_NUMFIRST: begin
        if (b == CH_X) begin
          do_grow = 1'b1; st_mid.mode = M_HEX; st_mid.kind = TK_HEX;
        end else if (is_digit(b)) begin
          do_grow = 1'b1; st_mid.mode = M_NUMBER;
        end else if (b == CH_DOT) begin
          do_grow = 1'b1; st_mid.mode = M_NUMBER; st_mid.dot = 1'b1;
          st_mid.kind = TK_FLOAT;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(b)) begin
          do_grow = 1'b1;
        end else if (b == CH_DOT && !st_r.dot) begin
          do_grow = 1'b1; st_mid.dot = 1'b1; st_mid.kind = TK_FLOAT;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_HEX: begin
        if (is_hex(b)) begin
          do_grow = 1'b1;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_LCOMMENT: begin
        if (b != CH_LF) begin
          do_grow = 1'b1;
        end else begin
          do_flush = 1'b1;
        end
      end
      M_BLOCK: begin
        do_grow = 1'b1;
        if (b == CH_STAR) begin
          st_mid.mode = M_BLOCKSTAR;
        end
      end
      M_BLOCKSTAR: begin
        if (b == CH_SLASH) begin
          do_cmp = 1'b1; cmp_kind = TK_BLOCK_CMT;
        end else begin
          do_grow = 1'b1;
          if (b != CH_STAR) begin
            st_mid.mode = M_BLOCK;
          end
        end
      end
      M_SQ: begin
        if (b == CH_SQUOTE) begin
          do_close = 1'b1;
        end else begin
          do_grow = 1'b1;
          if (b == CH_BSLASH) begin
            st_mid.mode = M_SQESC;
          end
        end
      end
      M_DQ: begin
        if (b == CH_DQUOTE) begin
          do_close = 1'b1;
        end else begin
          do_grow = 1'b1;
          if (b == CH_BSLASH) begin
            st_mid.mode = M_DQESC;
          end
        end
      end
      M_SQESC: begin
        do_grow = 1'b1; st_mid.mode = M_SQ;
      end
      M_DQESC: begin
        do_grow = 1'b1; st_mid.mode = M_DQ;
      end
      default: begin
        st_mid.mode = M_IDLE;
      end
    endcase

    taken    = do_cmp || do_grow || do_close;
    ext_emit = do_cmp || do_flush || do_close;
    ext_kind = do_cmp ? cmp_kind : st_r.kind;
    ext_len  = do_cmp ? inc_len(st_r.len) : st_r.len;
    if (do_grow) begin
      st_mid.len = inc_len(st_r.len);
    end
    if (ext_emit) begin
      st_mid.mode = M_IDLE;
    end

    cr_skip  = 1'b0;
    st_emit  = 1'b0;
    st_kind  = TK_UNDEF;
    beg      = 1'b0;
    beg_str  = 1'b0;
    beg_mode = M_IDLE;
    beg_kind = TK_UNDEF;
    if (!taken) begin
      case (b)
        CH_SP, CH_TAB, CH_LF: begin
        end
        CH_CR: begin
          cr_skip = 1'b1;
        end
        CH_LBRACE: begin st_emit = 1'b1; st_kind = TK_LBRACE; end
        CH_RBRACE: begin st_emit = 1'b1; st_kind = TK_RBRACE; end
        CH_LPAREN: begin st_emit = 1'b1; st_kind = TK_LPAREN; end
        CH_RPAREN: begin st_emit = 1'b1; st_kind = TK_RPAREN; end
        CH_LBRACK: begin st_emit = 1'b1; st_kind = TK_LBRACK; end
        CH_RBRACK: begin st_emit = 1'b1; st_kind = TK_RBRACK; end
        CH_SEMI:   begin st_emit = 1'b1; st_kind = TK_SEMI; end
        CH_DOT:    begin st_emit = 1'b1; st_kind = TK_DOT; end
        CH_COMMA:  begin st_emit = 1'b1; st_kind = TK_COMMA; end
        CH_BANG:   begin st_emit = 1'b1; st_kind = TK_BANG; end
        CH_QUEST:  begin st_emit = 1'b1; st_kind = TK_QUEST; end
        CH_BSLASH: begin st_emit = 1'b1; st_kind = TK_BSLASH; end
        CH_MINUS:  begin beg = 1'b1; beg_mode = M_MINUS;    beg_kind = TK_MINUS; end
        CH_PLUS:   begin beg = 1'b1; beg_mode = M_PLUS;     beg_kind = TK_PLUS; end
        CH_STAR:   begin beg = 1'b1; beg_mode = M_STAR;     beg_kind = TK_STAR; end
        CH_SLASH:  begin beg = 1'b1; beg_mode = M_SLASH;    beg_kind = TK_SLASH; end
        CH_HASH:   begin beg = 1'b1; beg_mode = M_LCOMMENT; beg_kind = TK_LINE_CMT; end
        CH_LT:     begin beg = 1'b1; beg_mode = M_LESS;     beg_kind = TK_LT; end
        CH_GT:     begin beg = 1'b1; beg_mode = M_GREATER;  beg_kind = TK_GT; end
        CH_AMP:    begin beg = 1'b1; beg_mode = M_AMP;      beg_kind = TK_AMP; end
        CH_PIPE:   begin beg = 1'b1; beg_mode = M_PIPE;     beg_kind = TK_PIPE; end
        CH_EQ:     begin beg = 1'b1; beg_mode = M_EQ;       beg_kind = TK_ASSIGN; end
        CH_COLON:  begin beg = 1'b1; beg_mode = M_COLON;    beg_kind = TK_COLON; end
        CH_DOLLAR: begin beg = 1'b1; beg_mode = M_WORD;     beg_kind = TK_LITERAL; end
        CH_SQUOTE: begin
          beg = 1'b1; beg_str = 1'b1; beg_mode = M_SQ; beg_kind = TK_SQ_STR;
        end
        CH_DQUOTE: begin
          beg = 1'b1; beg_str = 1'b1; beg_mode = M_DQ; beg_kind = TK_DQ_STR;
        end
        default: begin
          if (is_letter(b)) begin
            beg = 1'b1; beg_mode = M_WORD; beg_kind = TK_LITERAL;
          end else if (is_digit(b)) begin
            beg = 1'b1; beg_mode = M_NUMFIRST; beg_kind = TK_INT;
          end else begin
            st_emit = 1'b1; st_kind = TK_UNDEF;
          end
        end
      endcase
    end

    st_nxt = st_mid;
    if (beg) begin
      st_nxt.mode  = beg_mode;
      st_nxt.kind  = beg_kind;
      st_nxt.start = beg_str ? st_r.off + OFFSET_BITS'(1) : st_r.off;
      st_nxt.line  = st_r.cur_line;
      st_nxt.col   = beg_str ? inc_col(st_r.cur_col) : st_r.cur_col;
      st_nxt.len   = beg_str ? '0 : LENGTH_BITS'(1);
      st_nxt.dot   = 1'b0;
    end
    st_nxt.off = st_r.off + OFFSET_BITS'(1);
    if (b == CH_LF) begin
      st_nxt.cur_line = inc_line(st_r.cur_line);
      st_nxt.cur_col  = COLUMN_BITS'(1);
    end else if (!cr_skip) begin
      st_nxt.cur_col = inc_col(st_r.cur_col);
    end

    eot_emit = in_data.end_of_text && (st_nxt.mode != M_IDLE);
    eot_item = '{token_kind: st_nxt.kind, start_offset: st_nxt.start,
                 token_length: st_nxt.len, line_number: st_nxt.line,
                 column_number: st_nxt.col, run_last: 1'b1};
    if (in_data.end_of_text) begin
      st_nxt = ST_RESET;
    end
  end

  always_comb begin
    ext_item = '{token_kind: ext_kind, start_offset: st_r.start,
                 token_length: ext_len, line_number: st_r.line,
                 column_number: st_r.col, run_last: 1'b0};
    st_item  = '{token_kind: st_kind, start_offset: st_r.off,
                 token_length: LENGTH_BITS'(1), line_number: st_r.cur_line,
                 column_number: st_r.cur_col, run_last: 1'b0};
    push.cnt = 2'(ext_emit) + 2'(st_emit) + 2'(eot_emit);
    if (ext_emit) begin
      push.item0 = ext_item;
      push.item1 = st_emit ? st_item : eot_item;
    end else begin
      push.item0 = st_emit ? st_item : eot_item;
      push.item1 = eot_item;
    end
    push.item0.run_last = (push.cnt == 2'd1);
    push.item1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/core/slt_outq.sv]
// Result queue: four token items, taking up to two per cycle and giving one while out_ready is high.
// Depends on slt_pkg.
module slt_outq import slt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  slt_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign room      = (count_r < 3'd3);
  assign out_valid = (count_r != 3'd0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push_en ? push.cnt : 2'd0;

  always_comb begin
    wp_nxt    = wp_r + n_push;
    rp_nxt    = rp_r + 2'(pop);
    count_nxt = count_r + 3'(n_push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wp_r] <= push.item0;
    end
    if (n_push == 2'd2) begin
      mem_r[wp_r + 2'd1] <= push.item1;
    end
  end

endmodule

[rtl/core/slt_checker.sv]
// Port-level checks for the source lexer tokenizer, bound to the top level.
// Depends on slt_pkg and source_lexer_tokenizer.
module slt_checker import slt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item visible right after reset");

  a_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.token_kind <= TK_LAST) && (out_data.line_number != '0) &&
                  (out_data.column_number != '0))
    else $error("result item with bad kind, line or column");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result item changed");

endmodule

bind source_lexer_tokenizer slt_checker u_slt_checker (.*);
